// ----- hw/rtl/flr_pkg.sv -----
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types, byte codes and the header decode for the framed link receiver.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  localparam logic [7:0] ADDR_CMD  = 8'h03;
  localparam logic [7:0] ADDR_RSP  = 8'h01;

  localparam logic [7:0] CTRL_INFO0 = 8'h00;
  localparam logic [7:0] CTRL_INFO1 = 8'h40;
  localparam logic [7:0] CTRL_SET   = 8'h03;
  localparam logic [7:0] CTRL_DISC  = 8'h0B;
  localparam logic [7:0] CTRL_UA    = 8'h07;
  localparam logic [7:0] CTRL_RR0   = 8'h05;
  localparam logic [7:0] CTRL_RR1   = 8'h85;
  localparam logic [7:0] CTRL_REJ0  = 8'h01;
  localparam logic [7:0] CTRL_REJ1  = 8'h81;

  localparam int unsigned QDEPTH = 2;           // power of two, pointers wrap
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam int unsigned LEN_W  = 9;
  localparam int unsigned OUT_DW = 24;

  typedef enum logic [1:0] {
    CLS_DATA  = 2'd0,
    CLS_FLAG  = 2'd1,
    CLS_ESC   = 2'd2,
    CLS_ABORT = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    FT_INFO = 3'd0,
    FT_SET  = 3'd1,
    FT_DISC = 3'd2,
    FT_UA   = 3'd3,
    FT_RR   = 3'd4,
    FT_REJ  = 3'd5
  } frame_e;

  typedef enum logic [2:0] {
    PH_HUNT       = 3'd0,
    PH_HEADER     = 3'd1,
    PH_WAIT_CLOSE = 3'd2,
    PH_INFO       = 3'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    ROLE_TX = 1'b0,
    ROLE_RX = 1'b1
  } role_e;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    frame_e           ftype;
    logic             seq;
    logic [LEN_W-1:0] len;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic   ok;
    frame_e ftype;
    logic   seq;
  } hdr_t;

  function automatic hdr_t decode_header(role_e role, logic [7:0] a, logic [7:0] c);
    hdr_t h;
    h = '{ok: 1'b0, ftype: FT_INFO, seq: 1'b0};
    if (role == ROLE_TX) begin
      if (a == ADDR_CMD) begin
        case (c)
          CTRL_UA:   h = '{ok: 1'b1, ftype: FT_UA,  seq: 1'b0};
          CTRL_REJ0: h = '{ok: 1'b1, ftype: FT_REJ, seq: 1'b0};
          CTRL_REJ1: h = '{ok: 1'b1, ftype: FT_REJ, seq: 1'b1};
          CTRL_RR0:  h = '{ok: 1'b1, ftype: FT_RR,  seq: 1'b0};
          CTRL_RR1:  h = '{ok: 1'b1, ftype: FT_RR,  seq: 1'b1};
          default:   h.ok = 1'b0;
        endcase
      end else if (a == ADDR_RSP && c == CTRL_DISC) begin
        h = '{ok: 1'b1, ftype: FT_DISC, seq: 1'b0};
      end
    end else begin
      if (a == ADDR_CMD) begin
        case (c)
          CTRL_INFO0: h = '{ok: 1'b1, ftype: FT_INFO, seq: 1'b0};
          CTRL_INFO1: h = '{ok: 1'b1, ftype: FT_INFO, seq: 1'b1};
          CTRL_SET:   h = '{ok: 1'b1, ftype: FT_SET,  seq: 1'b0};
          CTRL_DISC:  h = '{ok: 1'b1, ftype: FT_DISC, seq: 1'b0};
          default:    h.ok = 1'b0;
        endcase
      end else if (a == ADDR_RSP && c == CTRL_UA) begin
        h = '{ok: 1'b1, ftype: FT_UA, seq: 1'b0};
      end
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/flr_front.sv -----
// ----------------------------------------------------------------------------
// flr_front
// Input side: takes line transactions and tags each byte with its class.
// ----------------------------------------------------------------------------
module flr_front (
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic          s_axis_tuser_i,   // func
  input  logic [7:0]    s_axis_tdata_i,   // rx_byte
  input  logic          q_full_i,
  output logic          q_push_o,
  output flr_pkg::item_t q_item_o
);
  import flr_pkg::*;

  cls_e cls;

  always_comb begin
    if (s_axis_tuser_i) begin
      cls = CLS_ABORT;
    end else if (s_axis_tdata_i == FLAG_BYTE) begin
      cls = CLS_FLAG;
    end else if (s_axis_tdata_i == ESC_BYTE) begin
      cls = CLS_ESC;
    end else begin
      cls = CLS_DATA;
    end
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;
  assign q_item_o        = '{cls: cls, data: s_axis_tdata_i};

endmodule

// ----- hw/rtl/flr_queue.sv -----
// ----------------------------------------------------------------------------
// flr_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module flr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  flr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output flr_pkg::item_t item_o
);
  import flr_pkg::*;

  item_t            mem_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == QCW'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- hw/rtl/flr_back.sv -----
// ----------------------------------------------------------------------------
// flr_back
// Frame state machine: header check, destuffing, BCC2 and the result register.
// ----------------------------------------------------------------------------
module flr_back #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  flr_pkg::role_e   role_i,
  input  logic             q_valid_i,
  input  flr_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output flr_pkg::result_t res_o
);
  import flr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  phase_e         phase_q, phase_d;
  logic [1:0]     hc_q, hc_d;
  logic [7:0]     addr_q, addr_d, ctrl_q, ctrl_d;
  frame_e         type_q, type_d;
  logic           seq_q, seq_d;
  logic           esc_q, esc_d;
  logic [7:0]     held_q, held_d;
  logic           hv_q, hv_d;
  logic [7:0]     xor_q, xor_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  logic           out_valid_q;
  result_t        out_q;

  logic           take;
  logic           emit;
  result_t        res;
  logic           hunt;
  phase_e         hunt_phase;
  logic           push_en;
  logic [7:0]     push_byte;
  hdr_t           hdr;
  logic [CW+LEN_W-1:0] cnt_ext;
  logic [LEN_W-1:0]    cnt_len;
  logic [7:0]     b;

  assign take    = q_valid_i && (!out_valid_q || res_ready_i);
  assign q_pop_o = take;
  assign hdr     = decode_header(role_i, addr_q, ctrl_q);
  assign cnt_ext = {{LEN_W{1'b0}}, cnt_q};
  assign cnt_len = cnt_ext[LEN_W-1:0];
  assign b       = q_item_i.data;

  always_comb begin
    phase_d    = phase_q;
    hc_d       = hc_q;
    addr_d     = addr_q;
    ctrl_d     = ctrl_q;
    type_d     = type_q;
    seq_d      = seq_q;
    esc_d      = esc_q;
    held_d     = held_q;
    hv_d       = hv_q;
    xor_d      = xor_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    res        = '0;
    hunt       = 1'b0;
    hunt_phase = PH_HUNT;
    push_en    = 1'b0;
    push_byte  = b;

    if (take) begin
      if (q_item_i.cls == CLS_ABORT) begin
        hunt = 1'b1;
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (q_item_i.cls == CLS_FLAG) begin
              phase_d = PH_HEADER;
              hc_d    = 2'd0;
            end
          end
          PH_HEADER: begin
            if (q_item_i.cls == CLS_FLAG) begin
              hc_d = 2'd0;
            end else if (hc_q == 2'd0) begin
              addr_d = b;
              hc_d   = 2'd1;
            end else if (hc_q == 2'd1) begin
              ctrl_d = b;
              hc_d   = 2'd2;
            end else begin
              hc_d = 2'd0;
              if (b == (addr_q ^ ctrl_q) && hdr.ok) begin
                type_d = hdr.ftype;
                seq_d  = hdr.seq;
                if (hdr.ftype == FT_INFO) begin
                  hunt       = 1'b1;
                  hunt_phase = PH_INFO;
                end else begin
                  phase_d = PH_WAIT_CLOSE;
                end
              end else begin
                hunt = 1'b1;
              end
            end
          end
          PH_WAIT_CLOSE: begin
            hunt = 1'b1;
            if (q_item_i.cls == CLS_FLAG) begin
              emit       = 1'b1;
              res.kind   = 1'b1;
              res.ftype  = type_q;
              res.seq    = seq_q;
              res.status = ST_OK;
              hunt_phase = PH_HEADER;
            end
          end
          PH_INFO: begin
            if (q_item_i.cls == CLS_FLAG) begin
              emit       = 1'b1;
              res.kind   = 1'b1;
              res.ftype  = FT_INFO;
              res.seq    = seq_q;
              if (hv_q) begin
                res.len    = cnt_len;
                res.status = (xor_q == held_q) ? ST_OK : ST_BAD;
              end else begin
                res.status = ST_BAD;
              end
              hunt       = 1'b1;
              hunt_phase = PH_HEADER;
            end else if (esc_q) begin
              esc_d     = 1'b0;
              push_en   = 1'b1;
              push_byte = b ^ ESC_XOR;
            end else if (q_item_i.cls == CLS_ESC) begin
              esc_d = 1'b1;
            end else begin
              push_en = 1'b1;
            end
          end
          default: begin
            hunt = 1'b1;
          end
        endcase
      end
    end

    if (push_en) begin
      if (hv_q && cnt_q >= CW'(MAX_PAYLOAD)) begin
        emit       = 1'b1;
        res.kind   = 1'b1;
        res.ftype  = FT_INFO;
        res.seq    = seq_q;
        res.len    = cnt_len;
        res.status = ST_OVERFLOW;
        hunt       = 1'b1;
      end else begin
        if (hv_q) begin
          emit     = 1'b1;
          res.kind = 1'b0;
          res.data = held_q;
          xor_d    = xor_q ^ held_q;
          cnt_d    = cnt_q + 1'b1;
        end
        held_d = push_byte;
        hv_d   = 1'b1;
      end
    end

    if (hunt) begin
      phase_d = hunt_phase;
      hc_d    = 2'd0;
      esc_d   = 1'b0;
      held_d  = 8'h00;
      hv_d    = 1'b0;
      xor_d   = 8'h00;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      hc_q        <= 2'd0;
      addr_q      <= 8'h00;
      ctrl_q      <= 8'h00;
      type_q      <= FT_INFO;
      seq_q       <= 1'b0;
      esc_q       <= 1'b0;
      held_q      <= 8'h00;
      hv_q        <= 1'b0;
      xor_q       <= 8'h00;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      addr_q  <= addr_d;
      ctrl_q  <= ctrl_d;
      type_q  <= type_d;
      seq_q   <= seq_d;
      esc_q   <= esc_d;
      held_q  <= held_d;
      hv_q    <= hv_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= res;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- hw/rtl/framed_link_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// framed_link_receiver_unit
// Byte-stuffed flag-delimited frame receiver with payload and report outputs.
// ----------------------------------------------------------------------------
// Takes one line byte (or a timeout abort) per cycle unless the queue is full
// and gives at most one result per byte: a destuffed payload byte, delayed by
// one payload byte so that the trailing BCC2 is never passed on, or a frame
// report at the closing flag or on overflow. Throughput is one byte per clock
// while the output is not stalled; each result passes the queue and an output
// register. A two-entry queue behind the input lets the line side keep going
// for two bytes while the output is stalled. The role register may be written
// only while no frame bytes are in flight.
module framed_link_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,       // role
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  input  logic        s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // data_byte, frame_type, seq_bit,
                                        // payload_length, status, pad
  output logic        m_axis_tuser_o,   // out_kind
  output logic        m_axis_tlast_o    // last_of_step
);
  import flr_pkg::*;

  role_e   role_q;
  logic    q_push, q_full, q_pop, q_valid;
  item_t   q_in, q_out;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q <= ROLE_TX;
    end else if (cfg_valid_i) begin
      role_q <= role_e'(cfg_data_i);
    end
  end

  flr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_item_o        (q_in)
  );

  flr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  flr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .role_i      (role_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {1'b0, res.status, res.len, res.seq, res.ftype, res.data};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = 1'b1;

  a_report_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'h00)
    else $error("frame report carries a data byte");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[23:8] == 16'h0000)
    else $error("payload byte carries report fields");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[22:21] != 2'd3)
    else $error("illegal status code");

  a_q_not_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed link receiver unit.
// ----------------------------------------------------------------------------
// A queue of line bytes and timeouts feeds a stream driver. A clocked monitor
// tracks the receiver state itself and predicts the payload bytes and frame
// reports. Every output transaction is compared with the oldest prediction.
// The stimulus covers directed frames for both roles and random frames:
// stuffed payloads, bad BCC1/BCC2, missing closing flags, dropped escapes,
// overflow, timeouts and line noise. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import flr_pkg::*;

  localparam int unsigned PAYLOAD_LIMIT = 256;

  typedef struct packed {
    logic       func;
    logic [7:0] b;
  } line_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    frame_e     ftype;
    logic       seq;
    logic [8:0] len;
    status_e    status;
  } frame_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_ready;
  logic        s_ready;
  logic        m_valid;
  logic [23:0] m_data;
  logic        m_user;
  logic        m_last;

  line_item_t    line_q[$];
  frame_report_t frame_out_q[$];
  logic [7:0]    payload_buf[$];
  logic [7:0]    last_line = 8'h00;

  int unsigned items_queued = 0;
  int unsigned acc_cnt = 0;
  int unsigned role_writes = 0;
  int unsigned hold_req = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned n_timeouts = 0;
  int unsigned n_payload = 0;
  int unsigned n_reports = 0;
  int unsigned n_bad = 0;
  int unsigned n_overflow = 0;

  // receiver state as the monitor sees it
  role_e       role_q = ROLE_TX;
  phase_e      ph = PH_HUNT;
  logic [1:0]  hdr_cnt = 2'd0;
  logic [7:0]  addr_b = 8'h00;
  logic [7:0]  ctrl_b = 8'h00;
  frame_e      dec_type = FT_INFO;
  logic        dec_seq = 1'b0;
  logic        esc_pend = 1'b0;
  logic [7:0]  held_b = 8'h00;
  logic        held_v = 1'b0;
  logic [7:0]  xor_acc = 8'h00;
  int unsigned pay_cnt = 0;

  framed_link_receiver_unit #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame();
    ph = PH_HUNT;
    hdr_cnt = 2'd0;
    esc_pend = 1'b0;
    held_b = 8'h00;
    held_v = 1'b0;
    xor_acc = 8'h00;
    pay_cnt = 0;
  endfunction

  function automatic void expect_out(logic kind, logic [7:0] d, frame_e ft, logic sq,
                                     int unsigned ln, status_e st);
    frame_report_t e;
    e.kind = kind;
    e.data = d;
    e.ftype = ft;
    e.seq = sq;
    e.len = ln[8:0];
    e.status = st;
    frame_out_q.push_back(e);
  endfunction

  function automatic bit header_match(logic [7:0] a, logic [7:0] c, output frame_e ft,
                                      output logic sq);
    ft = FT_INFO;
    sq = 1'b0;
    header_match = 1'b1;
    case ({role_q, a, c})
      {ROLE_TX, ADDR_CMD, CTRL_UA}:    ft = FT_UA;
      {ROLE_TX, ADDR_CMD, CTRL_REJ0}:  ft = FT_REJ;
      {ROLE_TX, ADDR_CMD, CTRL_REJ1}:  begin ft = FT_REJ; sq = 1'b1; end
      {ROLE_TX, ADDR_CMD, CTRL_RR0}:   ft = FT_RR;
      {ROLE_TX, ADDR_CMD, CTRL_RR1}:   begin ft = FT_RR; sq = 1'b1; end
      {ROLE_TX, ADDR_RSP, CTRL_DISC}:  ft = FT_DISC;
      {ROLE_RX, ADDR_CMD, CTRL_INFO0}: ft = FT_INFO;
      {ROLE_RX, ADDR_CMD, CTRL_INFO1}: sq = 1'b1;
      {ROLE_RX, ADDR_CMD, CTRL_SET}:   ft = FT_SET;
      {ROLE_RX, ADDR_CMD, CTRL_DISC}:  ft = FT_DISC;
      {ROLE_RX, ADDR_RSP, CTRL_UA}:    ft = FT_UA;
      default:                         header_match = 1'b0;
    endcase
  endfunction

  // payload goes out one byte late so the byte held at the flag is BCC2
  function automatic void take_payload_byte(logic [7:0] d);
    if (held_v) begin
      if (pay_cnt >= PAYLOAD_LIMIT) begin
        expect_out(1'b1, 8'h00, FT_INFO, dec_seq, pay_cnt, ST_OVERFLOW);
        clear_frame();
        return;
      end
      expect_out(1'b0, held_b, FT_INFO, 1'b0, 0, ST_OK);
      xor_acc ^= held_b;
      pay_cnt++;
    end
    held_b = d;
    held_v = 1'b1;
  endfunction

  function automatic void decode_line_byte(logic func, logic [7:0] b);
    frame_e ft;
    logic   sq;
    if (func) begin
      clear_frame();
      return;
    end
    case (ph)
      PH_HUNT: begin
        if (b == FLAG_BYTE) begin
          ph = PH_HEADER;
          hdr_cnt = 2'd0;
        end
      end
      PH_HEADER: begin
        if (b == FLAG_BYTE) begin
          hdr_cnt = 2'd0;
        end else if (hdr_cnt == 2'd0) begin
          addr_b = b;
          hdr_cnt = 2'd1;
        end else if (hdr_cnt == 2'd1) begin
          ctrl_b = b;
          hdr_cnt = 2'd2;
        end else begin
          hdr_cnt = 2'd0;
          if (b == (addr_b ^ ctrl_b) && header_match(addr_b, ctrl_b, ft, sq)) begin
            dec_type = ft;
            dec_seq = sq;
            if (ft == FT_INFO) begin
              clear_frame();
              ph = PH_INFO;
            end else begin
              ph = PH_WAIT_CLOSE;
            end
          end else begin
            clear_frame();
          end
        end
      end
      PH_WAIT_CLOSE: begin
        if (b == FLAG_BYTE) begin
          expect_out(1'b1, 8'h00, dec_type, dec_seq, 0, ST_OK);
          clear_frame();
          ph = PH_HEADER;
        end else begin
          clear_frame();
        end
      end
      PH_INFO: begin
        if (b == FLAG_BYTE) begin
          if (held_v) begin
            expect_out(1'b1, 8'h00, FT_INFO, dec_seq, pay_cnt,
                       (xor_acc == held_b) ? ST_OK : ST_BAD);
          end else begin
            expect_out(1'b1, 8'h00, FT_INFO, dec_seq, 0, ST_BAD);
          end
          clear_frame();
          ph = PH_HEADER;
        end else if (esc_pend) begin
          esc_pend = 1'b0;
          take_payload_byte(b ^ ESC_XOR);
        end else if (b == ESC_BYTE) begin
          esc_pend = 1'b1;
        end else begin
          take_payload_byte(b);
        end
      end
      default: clear_frame();
    endcase
  endfunction

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_report_t want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (frame_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_data, m_user);
          mismatch_cnt++;
        end else begin
          want = frame_out_q.pop_front();
          check_field("out_kind", want.kind, m_user);
          check_field("data_byte", want.data, m_data[7:0]);
          check_field("frame_type", want.ftype, m_data[10:8]);
          check_field("seq_bit", want.seq, m_data[11]);
          check_field("payload_length", want.len, m_data[20:12]);
          check_field("status", want.status, m_data[22:21]);
          check_field("last_of_step", 1, m_last);
          if (want.kind) begin
            n_reports++;
            if (want.status == ST_BAD) n_bad++;
            if (want.status == ST_OVERFLOW) n_overflow++;
          end else begin
            n_payload++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        role_q = role_e'(cfg_data);
        role_writes <= role_writes + 1;
      end
      if (s_valid && s_ready) begin
        decode_line_byte(s_user, s_data);
        if (s_user) n_timeouts++;
        acc_cnt <= acc_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------- driver / sink

  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      calm = $urandom_range(40, 160);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 48);
  endfunction

  int unsigned offer_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;

  always @(negedge clk_i) begin
    line_item_t it;
    if (!(s_valid && acc_cnt != offer_cnt)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_valid <= 1'b0;
      end else if (line_q.size() > 0) begin
        it = line_q.pop_front();
        s_valid <= 1'b1;
        s_data <= it.b;
        s_user <= it.func;
        offer_cnt++;
        tx_gap = next_gap(tx_calm);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_calm = 0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 300;
      m_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      rx_gap = next_gap(rx_calm);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_line(logic [7:0] b);
    line_q.push_back('{1'b0, b});
    last_line = b;
    items_queued++;
  endtask

  task automatic push_timeout();
    line_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
    last_line = 8'h00;
    items_queued++;
  endtask

  task automatic push_stuffed(logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        ((b ^ ESC_XOR) != FLAG_BYTE && $urandom_range(0, 31) == 0)) begin
      push_line(ESC_BYTE);
      push_line(b ^ ESC_XOR);
    end else begin
      push_line(b);
    end
  endtask

  task automatic fill_payload(int unsigned n);
    int unsigned r;
    payload_buf.delete();
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) payload_buf.push_back(FLAG_BYTE);
      else if (r == 1) payload_buf.push_back(ESC_BYTE);
      else payload_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_frame(logic [7:0] a, logic [7:0] c, bit bcc1_ok, bit bcc2_ok,
                            bit close, bit with_payload);
    logic [7:0] x;
    x = 8'h00;
    push_line(a);
    push_line(c);
    push_line(bcc1_ok ? (a ^ c) : (a ^ c ^ 8'($urandom_range(1, 255))));
    if (with_payload) begin
      foreach (payload_buf[i]) begin
        push_stuffed(payload_buf[i]);
        x ^= payload_buf[i];
      end
      push_stuffed(bcc2_ok ? x : ~x);
    end
    if (close) push_line(FLAG_BYTE);
  endtask

  task automatic random_frame(role_e r);
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  junk;
    int unsigned pick;
    int unsigned v;
    int unsigned len;
    bit          info;
    pick = $urandom_range(0, 99);
    a = ADDR_CMD;
    c = CTRL_UA;
    if (pick < 5) begin
      a = 8'($urandom_range(0, 255));
      c = 8'($urandom_range(0, 255));
    end else if ((pick < 90) == (r == ROLE_RX)) begin
      case ($urandom_range(0, 4))
        0:       c = CTRL_INFO0;
        1:       c = CTRL_INFO1;
        2:       c = CTRL_SET;
        3:       c = CTRL_DISC;
        default: begin a = ADDR_RSP; c = CTRL_UA; end
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0:       c = CTRL_UA;
        1:       c = CTRL_REJ0;
        2:       c = CTRL_REJ1;
        3:       c = CTRL_RR0;
        4:       c = CTRL_RR1;
        default: begin a = ADDR_RSP; c = CTRL_DISC; end
      endcase
    end
    info = (a == ADDR_CMD) && (c == CTRL_INFO0 || c == CTRL_INFO1);
    pick = $urandom_range(0, 399);
    if (pick == 0) len = $urandom_range(257, 260);
    else if (pick < 4) len = $urandom_range(150, 256);
    else len = $urandom_range(0, 14);
    fill_payload(len);
    if (last_line != FLAG_BYTE || $urandom_range(0, 5) == 0) push_line(FLAG_BYTE);
    v = $urandom_range(0, 99);
    send_frame(a, c, v >= 4, !(v >= 4 && v < 12), v >= 20,
               info && !(len == 0 && $urandom_range(0, 1) == 0));
    if (v >= 12 && v < 16) begin
      push_line(ESC_BYTE);
      push_line(FLAG_BYTE);
    end else if (v >= 16 && v < 20) begin
      junk = 8'($urandom_range(0, 255));
      push_line(junk == FLAG_BYTE ? 8'h00 : junk);
    end
  endtask

  task automatic random_traffic(role_e r, int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) push_timeout();
      else if (pick < 8) repeat ($urandom_range(1, 6)) push_line(8'($urandom_range(0, 255)));
      else if (pick < 11) push_line(FLAG_BYTE);
      else random_frame(r);
    end
  endtask

  task automatic wait_idle();
    int unsigned guard;
    while (acc_cnt != items_queued) @(negedge clk_i);
    guard = 0;
    while (frame_out_q.size() > 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    if (frame_out_q.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, frame_out_q.size());
      mismatch_cnt++;
      frame_out_q.delete();
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_role(role_e r);
    int unsigned seen;
    seen = role_writes;
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    while (role_writes == seen) @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    write_role(ROLE_RX);
    push_timeout();
    push_line(FLAG_BYTE);
    push_line(FLAG_BYTE);
    payload_buf.delete();
    payload_buf.push_back(8'hFF);
    payload_buf.push_back(FLAG_BYTE);
    payload_buf.push_back(8'h00);
    payload_buf.push_back(ESC_BYTE);
    send_frame(ADDR_CMD, CTRL_INFO1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_frame(ADDR_CMD, CTRL_INFO0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(ADDR_CMD, CTRL_SET, 1'b1, 1'b1, 1'b1, 1'b0);
    // escape pending when the flag arrives
    send_frame(ADDR_CMD, CTRL_INFO0, 1'b1, 1'b1, 1'b0, 1'b0);
    push_line(8'h41);
    push_line(ESC_BYTE);
    push_line(FLAG_BYTE);
    // timeout in the middle of a header
    push_line(ADDR_CMD);
    push_line(CTRL_DISC);
    push_timeout();
    push_line(FLAG_BYTE);
    wait_idle();

    // full-size frame and an overflow, with a long output stall up front
    hold_req++;
    push_line(FLAG_BYTE);
    fill_payload(PAYLOAD_LIMIT);
    send_frame(ADDR_CMD, CTRL_INFO0, 1'b1, 1'b1, 1'b1, 1'b1);
    fill_payload(PAYLOAD_LIMIT + 2);
    send_frame(ADDR_CMD, CTRL_INFO1, 1'b1, 1'b1, 1'b1, 1'b1);
    random_traffic(ROLE_RX, 250);
    wait_idle();
    random_traffic(ROLE_RX, 200);
    wait_idle();

    write_role(ROLE_TX);
    push_line(FLAG_BYTE);
    send_frame(ADDR_CMD, CTRL_UA, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(ADDR_CMD, CTRL_RR1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(ADDR_CMD, CTRL_REJ0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(ADDR_RSP, CTRL_DISC, 1'b1, 1'b1, 1'b1, 1'b0);
    send_frame(ADDR_CMD, CTRL_UA, 1'b1, 1'b1, 1'b0, 1'b0);
    push_line(8'h55);
    push_line(FLAG_BYTE);
    send_frame(ADDR_CMD, CTRL_RR0, 1'b0, 1'b1, 1'b1, 1'b0);
    wait_idle();
    hold_req++;
    random_traffic(ROLE_TX, 300);
    wait_idle();

    write_role(ROLE_RX);
    random_traffic(ROLE_RX, 250);
    wait_idle();

    $display("Run covered %0d line bytes (%0d timeouts) over %0d role writes",
             acc_cnt, n_timeouts, role_writes);
    $display("Checked %0d payload bytes and %0d frame reports (%0d bad, %0d overflow)",
             n_payload, n_reports, n_bad, n_overflow);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("%0t: timeout, simulation limit reached", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
